FILE: hw/rtl/mrd_pkg.sv
// Package for the message record deframer: phase and result kind codes,
// byte positions within the record fields. No dependencies.
package mrd_pkg;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_DATA   = 3'd1,
        PH_COUNT  = 3'd2,
        PH_VALUES = 3'd3,
        PH_DONE   = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        K_HEADER = 3'd0,
        K_DATA   = 3'd1,
        K_COUNT  = 3'd2,
        K_VALUE  = 3'd3,
        K_TRUNC  = 3'd4
    } kind_t;

    // last byte index of each header field, and of count and value words
    localparam logic [4:0] IDX_TYPE_END   = 5'd3;
    localparam logic [4:0] IDX_SHARD_END  = 5'd7;
    localparam logic [4:0] IDX_SENDER_END = 5'd11;
    localparam logic [4:0] IDX_SEQ_END    = 5'd19;
    localparam logic [4:0] IDX_HDR_END    = 5'd23;
    localparam logic [4:0] IDX_COUNT_END  = 5'd3;
    localparam logic [4:0] IDX_VALUE_END  = 5'd7;

    localparam int TDATA_W = 296;

endpackage

FILE: hw/rtl/message_record_deframer.sv
// Message record deframer: parses a big-endian record one byte per word.
// Latency: a result is shown on m_ the cycle after its byte is accepted.
// Throughput: one byte per cycle while m_tready is high; a byte that yields a
// record result and a truncation error holds s_tready low while both drain.
// The single result stage sets this: it frees as its last result is taken.
// Reset (aresetn low, synchronous) returns the parser to the header phase.
module message_record_deframer
    import mrd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,  // [7:0] in_byte
    input  logic               s_tlast,  // end_of_buffer
    output logic               m_tvalid,
    input  logic               m_tready,
    // [31:0] msg_type, [63:32] shard_num, [95:64] sender_num,
    // [159:96] seq_count, [191:160] data_length, [199:192] data_byte,
    // [231:200] ordering_count, [295:232] ordering_value
    output logic [TDATA_W-1:0] m_tdata,
    output logic [3:0]         m_tuser,  // [2:0] kind, [3] message_complete
    output logic               m_tlast   // last_of_run
);

    phase_t      phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [63:0] asm_reg, asm_next;
    logic [31:0] type_reg, type_next;
    logic [31:0] shard_reg, shard_next;
    logic [31:0] sender_reg, sender_next;
    logic [63:0] seq_reg, seq_next;
    logic [31:0] data_rem_reg, data_rem_next;
    logic [31:0] val_rem_reg, val_rem_next;

    logic               main_valid_reg, main_valid_next;
    logic               trunc_reg, trunc_next;
    kind_t              kind_reg;
    logic               complete_reg;
    logic [TDATA_W-1:0] data_reg;

    logic               res_valid;
    kind_t              res_kind;
    logic               res_complete;
    logic [TDATA_W-1:0] res_data;
    logic               res_trunc;
    logic [63:0]        asm_shift;
    logic               s_fire, m_fire;

    assign asm_shift = {asm_reg[55:0], s_tdata};
    assign s_fire    = s_tvalid && s_tready;
    assign m_fire    = m_tvalid && m_tready;

    // accept while the stage is empty or its only result goes out now
    assign s_tready = (!main_valid_reg && !trunc_reg)
                    || (m_tready && (main_valid_reg ^ trunc_reg));

    assign m_tvalid = main_valid_reg || trunc_reg;
    assign m_tdata  = main_valid_reg ? data_reg : '0;
    assign m_tuser  = main_valid_reg ? {complete_reg, kind_reg} : {1'b0, K_TRUNC};
    assign m_tlast  = !(main_valid_reg && trunc_reg);

    always_comb begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        asm_next      = asm_reg;
        type_next     = type_reg;
        shard_next    = shard_reg;
        sender_next   = sender_reg;
        seq_next      = seq_reg;
        data_rem_next = data_rem_reg;
        val_rem_next  = val_rem_reg;
        res_valid     = 1'b0;
        res_kind      = K_HEADER;
        res_complete  = 1'b0;
        res_data      = '0;
        res_trunc     = 1'b0;

        case (phase_reg)
            PH_HEADER: begin
                asm_next = asm_shift;
                case (idx_reg)
                    IDX_TYPE_END: begin
                        type_next = asm_shift[31:0];
                        asm_next  = '0;
                    end
                    IDX_SHARD_END: begin
                        shard_next = asm_shift[31:0];
                        asm_next   = '0;
                    end
                    IDX_SENDER_END: begin
                        sender_next = asm_shift[31:0];
                        asm_next    = '0;
                    end
                    IDX_SEQ_END: begin
                        seq_next = asm_shift;
                        asm_next = '0;
                    end
                    default: ;
                endcase
                if (idx_reg == IDX_HDR_END) begin
                    res_valid            = 1'b1;
                    res_kind             = K_HEADER;
                    res_data[31:0]       = type_reg;
                    res_data[63:32]      = shard_reg;
                    res_data[95:64]      = sender_reg;
                    res_data[159:96]     = seq_reg;
                    res_data[191:160]    = asm_shift[31:0];
                    asm_next             = '0;
                    idx_next             = '0;
                    data_rem_next        = asm_shift[31:0];
                    phase_next = (asm_shift[31:0] != 32'd0) ? PH_DATA : PH_COUNT;
                end else begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            PH_DATA: begin
                res_valid          = 1'b1;
                res_kind           = K_DATA;
                res_data[199:192]  = s_tdata;
                data_rem_next      = data_rem_reg - 32'd1;
                if (data_rem_reg == 32'd1) begin
                    phase_next = PH_COUNT;
                    idx_next   = '0;
                    asm_next   = '0;
                end
            end
            PH_COUNT: begin
                asm_next = asm_shift;
                if (idx_reg == IDX_COUNT_END) begin
                    res_valid          = 1'b1;
                    res_kind           = K_COUNT;
                    res_data[231:200]  = asm_shift[31:0];
                    asm_next           = '0;
                    idx_next           = '0;
                    val_rem_next       = asm_shift[31:0];
                    if (asm_shift[31:0] == 32'd0) begin
                        res_complete = 1'b1;
                        phase_next   = PH_DONE;
                    end else begin
                        phase_next = PH_VALUES;
                    end
                end else begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            PH_VALUES: begin
                asm_next = asm_shift;
                if (idx_reg == IDX_VALUE_END) begin
                    res_valid          = 1'b1;
                    res_kind           = K_VALUE;
                    res_data[295:232]  = asm_shift;
                    asm_next           = '0;
                    idx_next           = '0;
                    val_rem_next       = val_rem_reg - 32'd1;
                    if (val_rem_reg == 32'd1) begin
                        res_complete = 1'b1;
                        phase_next   = PH_DONE;
                    end
                end else begin
                    idx_next = idx_reg + 5'd1;
                end
            end
            default: phase_next = PH_DONE;
        endcase

        // end of buffer: flag an unfinished message and start afresh
        if (s_tlast) begin
            res_trunc     = (phase_next != PH_DONE);
            phase_next    = PH_HEADER;
            idx_next      = '0;
            asm_next      = '0;
            type_next     = '0;
            shard_next    = '0;
            sender_next   = '0;
            seq_next      = '0;
            data_rem_next = '0;
            val_rem_next  = '0;
        end
    end

    always_comb begin
        main_valid_next = main_valid_reg && !m_fire;
        trunc_next      = trunc_reg && !(m_fire && !main_valid_reg);
        if (s_fire) begin
            main_valid_next = res_valid;
            trunc_next      = res_trunc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HEADER;
            idx_reg        <= '0;
            asm_reg        <= '0;
            type_reg       <= '0;
            shard_reg      <= '0;
            sender_reg     <= '0;
            seq_reg        <= '0;
            data_rem_reg   <= '0;
            val_rem_reg    <= '0;
            main_valid_reg <= 1'b0;
            trunc_reg      <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            trunc_reg      <= trunc_next;
            if (s_fire) begin
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                asm_reg      <= asm_next;
                type_reg     <= type_next;
                shard_reg    <= shard_next;
                sender_reg   <= sender_next;
                seq_reg      <= seq_next;
                data_rem_reg <= data_rem_next;
                val_rem_reg  <= val_rem_next;
            end
        end
    end

    // hold the result payload until a new word replaces it
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg     <= res_kind;
            complete_reg <= res_complete;
            data_reg     <= res_data;
        end
    end

endmodule
